/* rtl/core/tssq_pkg.sv */
// ----------------------------------------------------------------------------
// tssq_pkg
// Shared types and codes for the timestamp sorted send queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tssq_pkg;

    // default number of queue cells
    localparam int unsigned TSSQ_DEPTH = 16;

    localparam int unsigned HANDLE_W = 32;
    localparam int unsigned STAMP_W  = 32;
    localparam int unsigned COUNT_W  = 5;
    localparam int unsigned STATUS_W = 2;

    // action codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_SEND   = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SENT     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_IDLE     = 2'd3;

    // one stored entry as it moves along the chain
    typedef struct packed {
        logic                valid;
        logic [HANDLE_W-1:0] handle;
        logic [STAMP_W-1:0]  stamp;
    } entry_t;

    // operation broadcast to every cell
    typedef struct packed {
        logic                do_insert;
        logic                do_shift_out;
        logic [HANDLE_W-1:0] handle;
        logic [STAMP_W-1:0]  stamp;
    } cell_cmd_t;

endpackage : tssq_pkg

`default_nettype wire

/* rtl/core/tssq_cell.sv */
// ----------------------------------------------------------------------------
// tssq_cell
// One slot of the sorted chain: holds, takes the new item, or takes a neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module tssq_cell
    import tssq_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cell_cmd_t cmd,
    input  wire entry_t    left_entry,
    input  wire logic      left_keep,
    input  wire entry_t    right_entry,
    output entry_t         entry,
    output logic           keep
);

    logic                valid_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [STAMP_W-1:0]  stamp_reg;
    entry_t              entry_next;

    // entry stays put on insert when its stamp is equal or smaller
    assign keep  = valid_reg && (stamp_reg <= cmd.stamp);
    assign entry = {valid_reg, handle_reg, stamp_reg};

    // next slot contents
    always_comb
    begin
        entry_next = entry;
        if (cmd.do_insert)
        begin
            if (keep)
            begin
                entry_next = entry;
            end
            else if (left_keep)
            begin
                entry_next.valid  = 1'b1;
                entry_next.handle = cmd.handle;
                entry_next.stamp  = cmd.stamp;
            end
            else
            begin
                entry_next = left_entry;
            end
        end
        else if (cmd.do_shift_out)
        begin
            entry_next = right_entry;
        end
    end

    // valid flag is control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= entry_next.valid;
        end
    end

    // payload needs no reset
    always_ff @(posedge clk)
    begin
        handle_reg <= entry_next.handle;
        stamp_reg  <= entry_next.stamp;
    end

endmodule : tssq_cell

`default_nettype wire

/* rtl/core/timestamp_sorted_send_queue_top.sv */
// ----------------------------------------------------------------------------
// timestamp_sorted_send_queue_top
// Packet handle queue kept in ascending timestamp order in a chain of cells.
// ----------------------------------------------------------------------------
// An item (insert or send) is taken on every cycle with start high; busy is
// never raised. Each item gives one result on the cycle after it is taken,
// shown for that one cycle with done high; the receiver cannot stall it, so it
// must take every result as it appears. Throughput is one item per cycle: all
// cells compare the item's timestamp against their own entry in parallel and
// shift in one step, so the single compare per cell sets the rate. Inserts
// behind equal timestamps keep arrival order; a send removes the head only if
// its timestamp is strictly below the item's current time.
// ----------------------------------------------------------------------------
`default_nettype none

module timestamp_sorted_send_queue_top
    import tssq_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = TSSQ_DEPTH
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic                action,
    input  wire logic [HANDLE_W-1:0] packet_handle,
    input  wire logic [STAMP_W-1:0]  time_value,
    output logic                     done,
    output logic [STATUS_W-1:0]      status,
    output logic [HANDLE_W-1:0]      sent_handle,
    output logic [STAMP_W-1:0]       sent_timestamp,
    output logic [COUNT_W-1:0]       entry_count
);

    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    entry_t            cell_entry [QUEUE_DEPTH];
    logic              cell_keep  [QUEUE_DEPTH];
    cell_cmd_t         cmd;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              is_full;
    logic              head_due;
    logic              done_reg;
    logic              done_next;
    logic [STATUS_W-1:0] status_reg;
    logic [STATUS_W-1:0] status_next;
    logic [HANDLE_W-1:0] handle_reg;
    logic [HANDLE_W-1:0] handle_next;
    logic [STAMP_W-1:0]  stamp_reg;
    logic [STAMP_W-1:0]  stamp_next;

    assign busy     = 1'b0;
    assign is_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_due = cell_entry[0].valid && (cell_entry[0].stamp < time_value);

    // broadcast command to the chain
    always_comb
    begin
        cmd.do_insert    = start && (action == ACT_INSERT) && !is_full;
        cmd.do_shift_out = start && (action == ACT_SEND) && head_due;
        cmd.handle       = packet_handle;
        cmd.stamp        = time_value;
    end

    // chain of cells
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        entry_t left_e;
        entry_t right_e;
        logic   left_k;

        if (i == 0)
        begin : g_first
            assign left_e = '0;
            assign left_k = 1'b1;
        end
        else
        begin : g_mid
            assign left_e = cell_entry[i-1];
            assign left_k = cell_keep[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign right_e = '0;
        end
        else
        begin : g_inner
            assign right_e = cell_entry[i+1];
        end

        tssq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .left_entry  (left_e),
            .left_keep   (left_k),
            .right_entry (right_e),
            .entry       (cell_entry[i]),
            .keep        (cell_keep[i])
        );
    end

    // result and fill count for the item being taken
    always_comb
    begin
        count_next  = count_reg;
        done_next   = start;
        status_next = status_reg;
        handle_next = handle_reg;
        stamp_next  = stamp_reg;
        if (start)
        begin
            handle_next = '0;
            stamp_next  = '0;
            if (action == ACT_INSERT)
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    status_next = ST_INSERTED;
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            else if (head_due)
            begin
                status_next = ST_SENT;
                handle_next = cell_entry[0].handle;
                stamp_next  = cell_entry[0].stamp;
                count_next  = count_reg - CNT_W'(1);
            end
            else
            begin
                status_next = ST_IDLE;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= done_next;
        end
    end

    // result payload and count seen by the receiver
    logic [COUNT_W-1:0] count_out_reg;

    always_ff @(posedge clk)
    begin
        status_reg    <= status_next;
        handle_reg    <= handle_next;
        stamp_reg     <= stamp_next;
        count_out_reg <= COUNT_W'(count_next);
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign sent_handle    = handle_reg;
    assign sent_timestamp = stamp_reg;
    assign entry_count    = count_out_reg;

endmodule : timestamp_sorted_send_queue_top

`default_nettype wire
